// ===== hw/rtl/rgb2hsv_pkg.sv =====
package rgb2hsv_pkg;

  localparam int CH_W           = 8;
  localparam int QW             = 16;
  localparam int NUM_W          = 11;
  localparam int DIV_STAGES_DEF = 4;
  localparam int DIV_STEPS_DEF  = QW / DIV_STAGES_DEF;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 40;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [CH_W-1:0] v;
    logic [CH_W-1:0] c;
    sector_t         sec;
    logic signed [CH_W:0] d;
  } mm_t;

  typedef struct packed {
    logic [QW-1:0]    q_hue;
    logic [NUM_W-1:0] rem_hue;
    logic [NUM_W-1:0] div_hue;
    logic [QW-1:0]    q_sat;
    logic [CH_W-1:0]  rem_sat;
    logic [CH_W-1:0]  v;
    logic             hue_zero;
    logic             sat_full;
  } div_t;

endpackage

// ===== hw/rtl/rgb2hsv_minmax.sv =====
module rgb2hsv_minmax (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rgb2hsv_pkg::CH_W-1:0] red,
  input  logic [rgb2hsv_pkg::CH_W-1:0] green,
  input  logic [rgb2hsv_pkg::CH_W-1:0] blue,
  output rgb2hsv_pkg::mm_t             mm_r
);
  import rgb2hsv_pkg::*;

  logic [CH_W-1:0] v;
  logic [CH_W-1:0] m;
  mm_t             mm_nxt;

  always_comb begin
    v = red;
    if (green > v) v = green;
    if (blue > v) v = blue;
    m = red;
    if (green < m) m = green;
    if (blue < m) m = blue;

    mm_nxt.v = v;
    mm_nxt.c = v - m;
    // ties go to red first, then green
    if (v == red) begin
      mm_nxt.sec = SEC_RED;
      mm_nxt.d   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (v == green) begin
      mm_nxt.sec = SEC_GREEN;
      mm_nxt.d   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      mm_nxt.sec = SEC_BLUE;
      mm_nxt.d   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm_r <= mm_nxt;
    end
  end

endmodule

// ===== hw/rtl/rgb2hsv_setup.sv =====
module rgb2hsv_setup (
  input  logic              clk,
  input  logic              en,
  input  rgb2hsv_pkg::mm_t  mm,
  output rgb2hsv_pkg::div_t div_r
);
  import rgb2hsv_pkg::*;

  logic [NUM_W-1:0]      c2;
  logic [NUM_W-1:0]      c4;
  logic [NUM_W-1:0]      c6;
  logic [NUM_W-1:0]      base;
  logic signed [NUM_W:0] num;
  logic signed [NUM_W:0] num_adj;
  div_t                  div_nxt;

  always_comb begin
    c2 = {2'b00, mm.c, 1'b0};
    c4 = {1'b0, mm.c, 2'b00};
    c6 = c2 + c4;
    case (mm.sec)
      SEC_RED:   base = '0;
      SEC_GREEN: base = c2;
      SEC_BLUE:  base = c4;
      default:   base = '0;
    endcase
    num = $signed({1'b0, base}) + $signed({{(NUM_W - CH_W){mm.d[CH_W]}}, mm.d});
    // negative hue wraps by one full turn
    if (num[NUM_W]) num_adj = num + $signed({1'b0, c6});
    else            num_adj = num;

    div_nxt.q_hue    = '0;
    div_nxt.rem_hue  = num_adj[NUM_W-1:0];
    div_nxt.div_hue  = c6;
    div_nxt.q_sat    = '0;
    div_nxt.rem_sat  = mm.c;
    div_nxt.v        = mm.v;
    div_nxt.hue_zero = (mm.c == '0);
    div_nxt.sat_full = (mm.c == mm.v) && (mm.c != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

endmodule

// ===== hw/rtl/rgb2hsv_div_step.sv =====
module rgb2hsv_div_step #(
  parameter int STEPS = rgb2hsv_pkg::DIV_STEPS_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  rgb2hsv_pkg::div_t din,
  output rgb2hsv_pkg::div_t div_r
);
  import rgb2hsv_pkg::*;

  logic [NUM_W:0] rh2;
  logic [CH_W:0]  rs2;
  div_t           div_nxt;

  // restoring division, STEPS quotient bits of hue and saturation per stage
  always_comb begin
    div_nxt = din;
    rh2     = '0;
    rs2     = '0;
    for (int i = 0; i < STEPS; i++) begin
      rh2 = {div_nxt.rem_hue, 1'b0};
      if (rh2 >= {1'b0, div_nxt.div_hue}) begin
        div_nxt.rem_hue = NUM_W'(rh2 - {1'b0, div_nxt.div_hue});
        div_nxt.q_hue   = {div_nxt.q_hue[QW-2:0], 1'b1};
      end else begin
        div_nxt.rem_hue = rh2[NUM_W-1:0];
        div_nxt.q_hue   = {div_nxt.q_hue[QW-2:0], 1'b0};
      end
      rs2 = {div_nxt.rem_sat, 1'b0};
      if (rs2 >= {1'b0, div_nxt.v}) begin
        div_nxt.rem_sat = CH_W'(rs2 - {1'b0, div_nxt.v});
        div_nxt.q_sat   = {div_nxt.q_sat[QW-2:0], 1'b1};
      end else begin
        div_nxt.rem_sat = rs2[CH_W-1:0];
        div_nxt.q_sat   = {div_nxt.q_sat[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r <= div_nxt;
    end
  end

endmodule

// ===== hw/rtl/rgb_to_hsv_pixel.sv =====
// rgb to hsv pixel converter, fully pipelined
// stages: min/max, setup, then DIV_STAGES divider stages, input to result
// throughput: one pixel per cycle while the output is not stalled; each divider
// stage resolves 16/DIV_STAGES quotient bits of hue and saturation, which sets depth
// reset: synchronous active-low rst_n clears the stage valid bits only
module rgb_to_hsv_pixel #(
  parameter int DIV_STAGES = rgb2hsv_pkg::DIV_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rgb2hsv_pkg::IN_DATA_W-1:0]  in_tdata,   // red, green, blue
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rgb2hsv_pkg::OUT_DATA_W-1:0] out_tdata   // hue, saturation, brightness
);
  import rgb2hsv_pkg::*;

  localparam int STAGES = DIV_STAGES + 2;
  localparam int STEPS  = QW / DIV_STAGES;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES-1:0] valid_in;
  logic [STAGES-1:0] ready;
  logic [STAGES-1:0] en;
  mm_t               mm;
  div_t              dv [DIV_STAGES+1];
  div_t              fin;
  logic [QW-1:0]     hue;
  logic [QW-1:0]     sat;

  // per-stage ready lets bubbles collapse while the output stalls
  always_comb begin
    valid_in = {valid_r[STAGES-2:0], in_tvalid};
    ready[STAGES-1] = !valid_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid_r[i] || ready[i+1];
    end
    en        = ready & valid_in;
    valid_nxt = (ready & valid_in) | (~ready & valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  rgb2hsv_minmax u_minmax (
    .clk   (clk),
    .en    (en[0]),
    .red   (in_tdata[CH_W-1:0]),
    .green (in_tdata[2*CH_W-1:CH_W]),
    .blue  (in_tdata[3*CH_W-1:2*CH_W]),
    .mm_r  (mm)
  );

  rgb2hsv_setup u_setup (
    .clk   (clk),
    .en    (en[1]),
    .mm    (mm),
    .div_r (dv[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rgb2hsv_div_step #(
      .STEPS (STEPS)
    ) u_div_step (
      .clk   (clk),
      .en    (en[g+2]),
      .din   (dv[g]),
      .div_r (dv[g+1])
    );
  end

  // black pixel has no saturation
  always_comb begin
    fin = dv[DIV_STAGES];
    hue = fin.hue_zero ? '0 : fin.q_hue;
    sat = (fin.v == '0) ? '0 : (fin.sat_full ? '1 : fin.q_sat);
  end

  assign in_tready  = ready[0];
  assign out_tvalid = valid_r[STAGES-1];
  assign out_tdata  = {fin.v, sat, hue};

`ifndef NO_ASSERTIONS
  a_reset_clears : assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_accept_needs_bubble : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && out_tvalid && !out_tready) |->
      ($countones(valid_r) < STAGES))
    else $error("input transaction taken into a full stalled pipeline");

  a_rem_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !fin.hue_zero) |-> (fin.rem_hue < fin.div_hue))
    else $error("hue remainder not below divisor");

  a_gray_hue : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && sat == '0) |-> (hue == '0))
    else $error("nonzero hue on a gray pixel");
`endif

endmodule
